>>> sv/lrpt_pkg.sv
// Shared types and constants for the looped ramp progress timer.
// No dependencies; used by looped_ramp_progress_timer_core.
`default_nettype none

package lrpt_pkg;

    // Input transaction opcodes
    typedef enum logic [2:0] {
        OP_TICK   = 3'd0,
        OP_START  = 3'd1,
        OP_PAUSE  = 3'd2,
        OP_RESUME = 3'd3,
        OP_STOP   = 3'd4
    } op_t;

    // Run modes
    typedef enum logic [1:0] {
        MODE_STOPPED = 2'd0,
        MODE_RUNNING = 2'd1,
        MODE_PAUSED  = 2'd2
    } mode_t;

    // Result event codes
    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_ADVANCED = 3'd1,
        EV_LOOP     = 3'd2,
        EV_ENDED    = 3'd3,
        EV_STARTED  = 3'd4
    } event_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_DURATION     = 3'd0,
        CFG_LOOP_TOTAL   = 3'd1,
        CFG_ENDLESS      = 3'd2,
        CFG_PING_PONG    = 3'd3,
        CFG_SET_BACKWARD = 3'd4
    } cfg_idx_t;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_DIV  = 2'd1,
        S_PUT  = 2'd2
    } seq_state_t;

    localparam int STEP_W     = 10;
    localparam int S_TDATA_W  = 16;
    localparam int LOOP_W     = 8;
    localparam int CFG_IDX_W  = 3;

endpackage

`default_nettype wire

>>> sv/lrpt_div.sv
// Restoring divider, one quotient bit per cycle, for the progress fraction.
// Computes floor(num * 2^FRAC_W / den) for num <= den; uses no package items.
`default_nettype none

module lrpt_div #(
    parameter int DEN_W  = 16,
    parameter int FRAC_W = 16
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [DEN_W:0]    num,
    input  wire logic [DEN_W-1:0]  den,
    output logic                   done,
    output logic [FRAC_W:0]        quot
);

    localparam int CNT_W = $clog2(FRAC_W + 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [DEN_W-1:0]    rem_reg, rem_next;
    logic [DEN_W-1:0]    den_reg, den_next;
    logic [FRAC_W:0]     quot_reg, quot_next;

    logic                int_bit;
    logic [DEN_W:0]      init_diff;
    logic [DEN_W:0]      rem_dbl;
    logic [DEN_W:0]      step_diff;
    logic                step_ge;

    // Integer bit and first remainder, then one shift-subtract per cycle
    always_comb begin
        int_bit   = (num >= {1'b0, den});
        init_diff = num - (int_bit ? {1'b0, den} : '0);
        rem_dbl   = {rem_reg, 1'b0};
        step_ge   = (rem_dbl >= {1'b0, den_reg});
        step_diff = rem_dbl - {1'b0, den_reg};

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quot_next = quot_reg;

        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(FRAC_W);
            rem_next  = init_diff[DEN_W-1:0];
            den_next  = den;
            quot_next = {{FRAC_W{1'b0}}, int_bit};
        end else if (busy_reg) begin
            rem_next  = step_ge ? step_diff[DEN_W-1:0] : rem_dbl[DEN_W-1:0];
            quot_next = {quot_reg[FRAC_W-1:0], step_ge};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

`ifndef SYNTHESIS
    // Done pulses once, after the last step
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg)
        else $error("divider done while still busy");
    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |=> !done_reg)
        else $error("divider done held for more than one cycle");
    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !start)
        else $error("divider started while busy");
`endif

endmodule

`default_nettype wire

>>> sv/looped_ramp_progress_timer_core.sv
// Looped ramp progress timer: control sequencer, state and result register.
// Depends on lrpt_pkg and instantiates the lrpt_div divider.
`default_nettype none

// Takes one transaction at a time. A tick that yields a progress fraction
// waits in the divide state for the restoring divider, which retires one
// quotient bit per cycle; every other item goes from idle straight to the
// put state, which hands the result to the output register. The
// next transaction is accepted while a finished result still waits in the
// output register. s_tready is high only while the sequencer is idle.
// Configuration writes are taken at any time and must only be issued while
// no transaction is in flight; writing set_backward sets the direction.
module looped_ramp_progress_timer_core #(
    parameter int PROGRESS_FRAC_BITS = 16,
    parameter int DURATION_BITS      = 16
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // Configuration write channel
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [lrpt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [DURATION_BITS-1:0]          cfg_data,
    // Input stream
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [lrpt_pkg::S_TDATA_W-1:0]    s_tdata,  // step_ms[9:0], zero pad
    input  wire logic [2:0]                        s_tuser,  // op[2:0]
    // Result stream
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [((PROGRESS_FRAC_BITS+19)/8)*8-1:0] m_tdata,
    // m_tdata from bit 0: progress, loop_index, run_state, backward, zero pad
    output logic [3:0]                             m_tuser   // update_valid, event_res
);

    localparam int F      = PROGRESS_FRAC_BITS;
    localparam int D      = DURATION_BITS;
    localparam int LW     = lrpt_pkg::LOOP_W;
    localparam int FIELDS = F + 1 + LW + 2 + 1;
    localparam int M_W    = ((F + 19) / 8) * 8;
    localparam logic [F:0]   PROG_ONE    = (F+1)'(1) << F;
    localparam logic [D:0]   ELAPSED_MAX = '1;

    // Configuration registers
    logic [D-1:0]   duration_reg, duration_next;
    logic [LW-1:0]  loop_total_reg, loop_total_next;
    logic           endless_reg, endless_next;
    logic           ping_pong_reg, ping_pong_next;

    // Timer state
    logic [D:0]              elapsed_reg, elapsed_next;
    logic [LW-1:0]           loop_reg, loop_next;
    lrpt_pkg::mode_t         mode_reg, mode_next;
    logic                    back_reg, back_next;

    // Sequencer and pending result
    lrpt_pkg::seq_state_t    state_reg, state_next;
    logic                    pend_upd_reg, pend_upd_next;
    logic [F:0]              pend_prog_reg, pend_prog_next;
    lrpt_pkg::event_t        pend_ev_reg, pend_ev_next;

    // Output register
    logic                    out_valid_reg, out_valid_next;
    logic                    out_upd_reg, out_upd_next;
    logic [F:0]              out_prog_reg, out_prog_next;
    logic [LW-1:0]           out_loop_reg, out_loop_next;
    lrpt_pkg::mode_t         out_mode_reg, out_mode_next;
    logic                    out_back_reg, out_back_next;
    lrpt_pkg::event_t        out_ev_reg, out_ev_next;

    // Tick datapath
    logic [lrpt_pkg::STEP_W-1:0] step_ms;
    lrpt_pkg::op_t               op;
    logic [D+1:0]                sum_full;
    logic [D:0]                  elapsed_sat;
    logic [D-1:0]                dur_eff;
    logic                        overrun;
    logic                        more_loops;
    logic                        back_flip;
    logic                        div_start;
    logic                        div_done;
    logic [F:0]                  div_quot;

    assign step_ms     = s_tdata[lrpt_pkg::STEP_W-1:0];
    assign op          = lrpt_pkg::op_t'(s_tuser);
    assign sum_full    = {1'b0, elapsed_reg} + (D+2)'(step_ms);
    assign elapsed_sat = sum_full[D+1] ? ELAPSED_MAX : sum_full[D:0];
    assign dur_eff     = (duration_reg == '0) ? D'(1) : duration_reg;
    assign overrun     = (elapsed_sat > {1'b0, dur_eff});
    assign more_loops  = endless_reg ||
                         (({1'b0, loop_reg} + (LW+1)'(1)) < {1'b0, loop_total_reg});
    assign back_flip   = back_reg ^ ping_pong_reg;

    lrpt_div #(
        .DEN_W  (D),
        .FRAC_W (F)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (elapsed_sat),
        .den     (dur_eff),
        .done    (div_done),
        .quot    (div_quot)
    );

    // Sequencer, state update and result staging
    always_comb begin
        duration_next   = duration_reg;
        loop_total_next = loop_total_reg;
        endless_next    = endless_reg;
        ping_pong_next  = ping_pong_reg;
        elapsed_next    = elapsed_reg;
        loop_next       = loop_reg;
        mode_next       = mode_reg;
        back_next       = back_reg;
        state_next      = state_reg;
        pend_upd_next   = pend_upd_reg;
        pend_prog_next  = pend_prog_reg;
        pend_ev_next    = pend_ev_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_upd_next    = out_upd_reg;
        out_prog_next   = out_prog_reg;
        out_loop_next   = out_loop_reg;
        out_mode_next   = out_mode_reg;
        out_back_next   = out_back_reg;
        out_ev_next     = out_ev_reg;
        div_start       = 1'b0;

        // Configuration writes
        if (cfg_valid) begin
            unique case (cfg_index)
                lrpt_pkg::CFG_DURATION:     duration_next   = cfg_data;
                lrpt_pkg::CFG_LOOP_TOTAL:   loop_total_next = cfg_data[LW-1:0];
                lrpt_pkg::CFG_ENDLESS:      endless_next    = cfg_data[0];
                lrpt_pkg::CFG_PING_PONG:    ping_pong_next  = cfg_data[0];
                lrpt_pkg::CFG_SET_BACKWARD: back_next       = cfg_data[0];
                default: ;
            endcase
        end

        unique case (state_reg)
            lrpt_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    pend_upd_next  = 1'b0;
                    pend_prog_next = '0;
                    pend_ev_next   = lrpt_pkg::EV_NONE;
                    state_next     = lrpt_pkg::S_PUT;
                    unique case (op)
                        lrpt_pkg::OP_TICK: begin
                            if (mode_reg == lrpt_pkg::MODE_RUNNING) begin
                                pend_upd_next = 1'b1;
                                elapsed_next  = elapsed_sat;
                                if (overrun && more_loops) begin
                                    // Begin the next loop
                                    elapsed_next   = '0;
                                    back_next      = back_flip;
                                    loop_next      = loop_reg + LW'(1);
                                    pend_prog_next = back_flip ? PROG_ONE : '0;
                                    pend_ev_next   = lrpt_pkg::EV_LOOP;
                                end else if (overrun) begin
                                    // Last loop done: final value and stop
                                    loop_next      = '0;
                                    mode_next      = lrpt_pkg::MODE_STOPPED;
                                    pend_prog_next = back_reg ? '0 : PROG_ONE;
                                    pend_ev_next   = lrpt_pkg::EV_ENDED;
                                end else begin
                                    // Fraction comes from the divider
                                    div_start    = 1'b1;
                                    pend_ev_next = lrpt_pkg::EV_ADVANCED;
                                    state_next   = lrpt_pkg::S_DIV;
                                end
                            end
                        end
                        lrpt_pkg::OP_START: begin
                            if (mode_reg != lrpt_pkg::MODE_RUNNING) begin
                                elapsed_next = '0;
                            end
                            mode_next    = lrpt_pkg::MODE_RUNNING;
                            pend_ev_next = lrpt_pkg::EV_STARTED;
                        end
                        lrpt_pkg::OP_PAUSE: begin
                            mode_next = lrpt_pkg::MODE_PAUSED;
                        end
                        lrpt_pkg::OP_RESUME: begin
                            if (mode_reg == lrpt_pkg::MODE_PAUSED) begin
                                elapsed_next = '0;
                                mode_next    = lrpt_pkg::MODE_RUNNING;
                            end
                        end
                        lrpt_pkg::OP_STOP: begin
                            loop_next    = '0;
                            mode_next    = lrpt_pkg::MODE_STOPPED;
                            pend_ev_next = lrpt_pkg::EV_ENDED;
                        end
                        default: ;
                    endcase
                end
            end
            lrpt_pkg::S_DIV: begin
                if (div_done) begin
                    pend_prog_next = back_reg ? (PROG_ONE - div_quot) : div_quot;
                    state_next     = lrpt_pkg::S_PUT;
                end
            end
            lrpt_pkg::S_PUT: begin
                // Hand the result to the output register once it is free
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_upd_next   = pend_upd_reg;
                    out_prog_next  = pend_prog_reg;
                    out_loop_next  = loop_reg;
                    out_mode_next  = mode_reg;
                    out_back_next  = back_reg;
                    out_ev_next    = pend_ev_reg;
                    state_next     = lrpt_pkg::S_IDLE;
                end
            end
            default: state_next = lrpt_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            duration_reg   <= D'(1);
            loop_total_reg <= LW'(1);
            endless_reg    <= 1'b0;
            ping_pong_reg  <= 1'b0;
            elapsed_reg    <= '0;
            loop_reg       <= '0;
            mode_reg       <= lrpt_pkg::MODE_STOPPED;
            back_reg       <= 1'b0;
            state_reg      <= lrpt_pkg::S_IDLE;
            out_valid_reg  <= 1'b0;
        end else begin
            duration_reg   <= duration_next;
            loop_total_reg <= loop_total_next;
            endless_reg    <= endless_next;
            ping_pong_reg  <= ping_pong_next;
            elapsed_reg    <= elapsed_next;
            loop_reg       <= loop_next;
            mode_reg       <= mode_next;
            back_reg       <= back_next;
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
        end
        pend_upd_reg  <= pend_upd_next;
        pend_prog_reg <= pend_prog_next;
        pend_ev_reg   <= pend_ev_next;
        out_upd_reg   <= out_upd_next;
        out_prog_reg  <= out_prog_next;
        out_loop_reg  <= out_loop_next;
        out_mode_reg  <= out_mode_next;
        out_back_reg  <= out_back_next;
        out_ev_reg    <= out_ev_next;
    end

    // Ports
    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == lrpt_pkg::S_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {{(M_W - FIELDS){1'b0}}, out_back_reg, out_mode_reg,
                        out_loop_reg, out_prog_reg};
    assign m_tuser   = {out_ev_reg, out_upd_reg};

`ifndef SYNTHESIS
    // Divider finishes only while the sequencer waits for it
    a_div_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == lrpt_pkg::S_DIV))
        else $error("divider result outside the divide state");
    // One transaction at a time
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted back to back");
    // Progress never exceeds 1.0
    a_prog_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_prog_reg <= PROG_ONE))
        else $error("progress above 1.0");
    // An ended result always reports a stopped timer
    a_end_stopped: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && (out_ev_reg == lrpt_pkg::EV_ENDED))
            |-> (out_mode_reg == lrpt_pkg::MODE_STOPPED))
        else $error("ended event while not stopped");
    // A progress value comes only with a tick event
    a_upd_event: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_upd_reg) |-> (out_ev_reg == lrpt_pkg::EV_ADVANCED ||
            out_ev_reg == lrpt_pkg::EV_LOOP || out_ev_reg == lrpt_pkg::EV_ENDED))
        else $error("progress update with a non-tick event");
`endif

endmodule

`default_nettype wire
